// File: hw/rtl/sequenced_price_table_unit_macros.svh
// assertion macros used by the checker file
`ifndef SEQUENCED_PRICE_TABLE_UNIT_MACROS_SVH
`define SEQUENCED_PRICE_TABLE_UNIT_MACROS_SVH

// property checked outside reset
`define SPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked also across reset
`define SPT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/spt_pkg.sv
package spt_pkg;

   // default table dimensions
   localparam int MAX_EXCHANGES_DEF   = 8;
   localparam int MAX_INSTRUMENTS_DEF = 1024;

   // stream widths
   localparam int REQ_DATA_W = 240;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 328;
   localparam int RSP_USER_W = 4;

   // commands
   localparam logic [1:0] CMD_UPDATE   = 2'd0;
   localparam logic [1:0] CMD_QUERY    = 2'd1;
   localparam logic [1:0] CMD_STATS    = 2'd2;
   localparam logic [1:0] CMD_CHECKSUM = 2'd3;

   // result status codes
   localparam logic [3:0] ST_ACCEPTED     = 4'd0;
   localparam logic [3:0] ST_GAP          = 4'd1;
   localparam logic [3:0] ST_DUPLICATE    = 4'd2;
   localparam logic [3:0] ST_STALE        = 4'd3;
   localparam logic [3:0] ST_BAD_EXCHANGE = 4'd4;
   localparam logic [3:0] ST_BAD_INSTR    = 4'd5;
   localparam logic [3:0] ST_BAD_PRICE    = 4'd6;
   localparam logic [3:0] ST_BAD_SEQ      = 4'd7;
   localparam logic [3:0] ST_PRICE        = 4'd8;
   localparam logic [3:0] ST_MISSING      = 4'd9;
   localparam logic [3:0] ST_NOT_FOUND    = 4'd10;
   localparam logic [3:0] ST_COUNTER      = 4'd11;
   localparam logic [3:0] ST_CHECKSUM     = 4'd12;

   // register indexes
   localparam logic [7:0] CSR_EXCHANGES   = 8'd0;
   localparam logic [7:0] CSR_INSTRUMENTS = 8'd1;

   // event counter indexes
   localparam logic [2:0] CNT_RECV  = 3'd0;
   localparam logic [2:0] CNT_ACC   = 3'd1;
   localparam logic [2:0] CNT_DUP   = 3'd2;
   localparam logic [2:0] CNT_STALE = 3'd3;
   localparam logic [2:0] CNT_GAPS  = 3'd4;
   localparam logic [2:0] CNT_MISS  = 3'd5;
   localparam logic [2:0] CNT_INVAL = 3'd6;
   localparam int         NUM_CNT   = 7;

   // fnv-1a: prime is 2^40 + 0x1b3
   localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
   localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
   localparam int          FNV_PRIME_SHIFT = 40;

   // hash unit control
   typedef struct packed {
      logic        init;
      logic        start;
      logic [63:0] data;
   } fnv_ctrl_type;

endpackage

// File: hw/rtl/spt_fnv.sv
// byte-serial fnv-1a hash unit, one byte a cycle
module spt_fnv import spt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fnv_ctrl_type ctrl,
   output logic         busy,
   output logic [63:0]  hash
);

   logic [63:0] h_ff, h_in;
   logic [63:0] d_ff, d_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] x;
   logic [63:0] step;

   // one mixing step: xor byte, multiply by prime as shift plus small product
   assign x    = h_ff ^ {56'd0, d_ff[7:0]};
   assign step = (x << FNV_PRIME_SHIFT) + (x * {55'd0, FNV_PRIME_LO});

   always_comb begin
      h_in    = h_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.init) begin
         h_in = FNV_BASIS;
      end
      if (ctrl.start) begin
         d_in    = ctrl.data;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         h_in   = step;
         d_in   = d_ff >> 8;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      h_ff <= h_in;
      d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign hash = h_ff;

endmodule

// File: hw/rtl/sequenced_price_table_unit.sv
// Price table per instrument and exchange with a last sequence per exchange. After reset the
// block sweeps the table to clear the valid marks, one entry a cycle, over all MAX_EXCHANGES *
// MAX_INSTRUMENTS entries (8192 by default), and takes no item meanwhile; csr writes are taken
// at any time. One item is worked at a time, all table reads going through the single table
// memory port with a registered read. An update reads in S_UPD_RD, then S_UPD_CHK writes its
// result to the output register once free, and idle takes the next item. A query runs (P + 1)
// passes over the in-use exchanges, P being the number of priced entries, with one emit per pass
// but the last, then one missing pass; a query for an unused instrument gives one not-found
// result. Stats give the seven event counters in turn; a checksum is set by the byte-serial
// hash unit over 64-bit words (2 + exchanges + 1 per entry, plus 3 per valid entry). Results
// wait in an output register, so the block can return to idle before the last result is taken.
module sequenced_price_table_unit import spt_pkg::*; #(
   parameter int MAX_EXCHANGES   = MAX_EXCHANGES_DEF,
   parameter int MAX_INSTRUMENTS = MAX_INSTRUMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // exchange[15:0], instrument[47:16], price[111:48], sequence_req[175:112],
   // timestamp[239:176]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // gap_size[63:0], exchange_out[66:64], price_out[129:67], sequence_out[193:130],
   // timestamp_out[257:194], value[321:258], zero pad[327:322]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[3:0]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_index,
   input  logic [10:0]           csr_data
);

   localparam int XW     = (MAX_EXCHANGES > 1) ? $clog2(MAX_EXCHANGES) : 1;
   localparam int IW     = (MAX_INSTRUMENTS > 1) ? $clog2(MAX_INSTRUMENTS) : 1;
   localparam int EW     = XW + 1;
   localparam int NW     = IW + 1;
   localparam int TABLE  = MAX_EXCHANGES * MAX_INSTRUMENTS;
   localparam int AW     = (TABLE > 1) ? $clog2(TABLE) : 1;
   localparam logic [3:0]  EX_RST = (MAX_EXCHANGES < 8) ? 4'(MAX_EXCHANGES) : 4'd8;
   localparam logic [10:0] IN_RST = (MAX_INSTRUMENTS < 1024) ? 11'(MAX_INSTRUMENTS)
                                                             : 11'd1024;
   localparam logic [AW-1:0] CLR_LAST = AW'(TABLE - 1);

   typedef struct packed {
      logic        vld;
      logic [62:0] price;
      logic [63:0] seq;
      logic [63:0] ts;
   } row_type;

   // sequencer states
   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_UPD_RD  = 5'd2;
   localparam logic [4:0] S_UPD_CHK = 5'd3;
   localparam logic [4:0] S_QRY_RD  = 5'd4;
   localparam logic [4:0] S_QRY_CMP = 5'd5;
   localparam logic [4:0] S_QRY_OUT = 5'd6;
   localparam logic [4:0] S_MIS_RD  = 5'd7;
   localparam logic [4:0] S_MIS_CHK = 5'd8;
   localparam logic [4:0] S_STAT    = 5'd9;
   localparam logic [4:0] S_ONE     = 5'd10;
   localparam logic [4:0] S_CK_EX   = 5'd11;
   localparam logic [4:0] S_CK_IN   = 5'd12;
   localparam logic [4:0] S_CK_SRD  = 5'd13;
   localparam logic [4:0] S_CK_SMIX = 5'd14;
   localparam logic [4:0] S_CK_RRD  = 5'd15;
   localparam logic [4:0] S_CK_RV   = 5'd16;
   localparam logic [4:0] S_CK_RP   = 5'd17;
   localparam logic [4:0] S_CK_RS   = 5'd18;
   localparam logic [4:0] S_CK_RT   = 5'd19;
   localparam logic [4:0] S_CK_OUT  = 5'd20;

   function automatic logic [3:0] clamp_ex(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (32'(v) > MAX_EXCHANGES) r = 4'(MAX_EXCHANGES);
      return r;
   endfunction

   function automatic logic [10:0] clamp_in(input logic [10:0] v);
      logic [10:0] r;
      r = v;
      if (v == 11'd0) r = 11'd1;
      else if (32'(v) > MAX_INSTRUMENTS) r = 11'(MAX_INSTRUMENTS);
      return r;
   endfunction

   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [3:0]    ex_use_ff, ex_use_in;
   logic [10:0]   in_use_ff, in_use_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic [15:0]   exch_ff, exch_in;
   logic [31:0]   instr_ff, instr_in;
   logic [63:0]   price_ff, price_in;
   logic [63:0]   seq_ff, seq_in;
   logic [63:0]   ts_ff, ts_in;

   logic [EW-1:0] e_ff, e_in;
   logic [NW-1:0] i_ff, i_in;
   logic [EW-1:0] nout_ff, nout_in;
   logic [2:0]    k_ff, k_in;

   logic          have_prev_ff, have_prev_in;
   logic [62:0]   prev_price_ff, prev_price_in;
   logic [XW-1:0] prev_exch_ff, prev_exch_in;
   logic          have_best_ff, have_best_in;
   row_type       best_ff, best_in;
   logic [XW-1:0] best_exch_ff, best_exch_in;

   logic [63:0]   cnt_ff [NUM_CNT];
   logic [63:0]   cnt_in [NUM_CNT];

   // sequence memory with reset-cleared valid marks
   logic [63:0]              seq_mem [MAX_EXCHANGES];
   logic [MAX_EXCHANGES-1:0] seq_vld_ff;
   logic [63:0]              seq_rd_ff;
   logic                     seq_rd_vld_ff;
   logic                     seq_we;
   logic [XW-1:0]            seq_addr;

   // table memory
   row_type       tbl_mem [TABLE];
   row_type       tbl_rd_ff;
   logic          tbl_we;
   logic [AW-1:0] tbl_addr;
   row_type       tbl_wd;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic         out_free;
   logic         emit;
   logic [3:0]   em_status;
   logic [63:0]  em_gap;
   logic [2:0]   em_exch;
   logic [62:0]  em_price;
   logic [63:0]  em_seq;
   logic [63:0]  em_ts;
   logic [63:0]  em_value;
   logic         em_last;

   fnv_ctrl_type fnv_ctrl;
   logic         fnv_busy;
   logic [63:0]  fnv_hash;

   logic          accept;
   logic [EW-1:0] e_nxt;
   logic [NW-1:0] i_nxt;
   logic [EW-1:0] nout_nxt;
   logic          e_last;
   logic          i_last;
   logic          out_last;
   logic [IW-1:0] row_i;
   logic [AW-1:0] row_addr;
   logic [AW-1:0] upd_addr;
   logic [63:0]   last_seq;
   logic [63:0]   miss;
   logic          bad_ex, bad_in, bad_pr, bad_sq, dup, stale;
   logic          cand, better;

   spt_fnv u_fnv (
      .clock (clock),
      .reset (reset),
      .ctrl  (fnv_ctrl),
      .busy  (fnv_busy),
      .hash  (fnv_hash)
   );

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // loop counters
   assign e_nxt    = e_ff + EW'(1);
   assign i_nxt    = i_ff + NW'(1);
   assign nout_nxt = nout_ff + EW'(1);
   assign e_last   = (32'(e_nxt) == 32'(ex_use_ff));
   assign i_last   = (32'(i_nxt) == 32'(in_use_ff));
   assign out_last = (32'(nout_nxt) == 32'(ex_use_ff));

   // table addressing, instrument-major
   assign row_i    = (cmd_ff == CMD_CHECKSUM) ? i_ff[IW-1:0] : instr_ff[IW-1:0];
   assign row_addr = AW'(32'(row_i) * MAX_EXCHANGES + 32'(e_ff[XW-1:0]));
   assign upd_addr = AW'(32'(instr_ff[IW-1:0]) * MAX_EXCHANGES + 32'(exch_ff[XW-1:0]));
   assign seq_addr = (cmd_ff == CMD_UPDATE) ? exch_ff[XW-1:0] : e_ff[XW-1:0];

   // update checks
   assign last_seq = seq_rd_vld_ff ? seq_rd_ff : 64'd0;
   assign bad_ex   = 32'(exch_ff) >= 32'(ex_use_ff);
   assign bad_in   = instr_ff >= 32'(in_use_ff);
   assign bad_pr   = (price_ff == 64'd0) || price_ff[63];
   assign bad_sq   = (seq_ff == 64'd0);
   assign dup      = (seq_ff == last_seq);
   assign stale    = (seq_ff < last_seq);
   assign miss     = seq_ff + ~last_seq;

   // query ordering by price then exchange
   assign cand   = tbl_rd_ff.vld && (!have_prev_ff || (tbl_rd_ff.price > prev_price_ff) ||
                   ((tbl_rd_ff.price == prev_price_ff) && (e_ff[XW-1:0] > prev_exch_ff)));
   assign better = !have_best_ff || (tbl_rd_ff.price < best_ff.price);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ex_use_in     = ex_use_ff;
      in_use_in     = in_use_ff;
      cmd_in        = cmd_ff;
      exch_in       = exch_ff;
      instr_in      = instr_ff;
      price_in      = price_ff;
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      e_in          = e_ff;
      i_in          = i_ff;
      nout_in       = nout_ff;
      k_in          = k_ff;
      have_prev_in  = have_prev_ff;
      prev_price_in = prev_price_ff;
      prev_exch_in  = prev_exch_ff;
      have_best_in  = have_best_ff;
      best_in       = best_ff;
      best_exch_in  = best_exch_ff;
      cnt_in        = cnt_ff;
      seq_we        = 1'b0;
      tbl_we        = 1'b0;
      tbl_addr      = row_addr;
      tbl_wd        = '0;
      fnv_ctrl      = '0;
      emit          = 1'b0;
      em_status     = ST_ACCEPTED;
      em_gap        = 64'd0;
      em_exch       = 3'd0;
      em_price      = 63'd0;
      em_seq        = 64'd0;
      em_ts         = 64'd0;
      em_value      = 64'd0;
      em_last       = 1'b0;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_EXCHANGES:   ex_use_in = clamp_ex(csr_data[3:0]);
            CSR_INSTRUMENTS: in_use_in = clamp_in(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            tbl_we   = 1'b1;
            tbl_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in       = req_tuser[1:0];
               exch_in      = req_tdata[15:0];
               instr_in     = req_tdata[47:16];
               price_in     = req_tdata[111:48];
               seq_in       = req_tdata[175:112];
               ts_in        = req_tdata[239:176];
               e_in         = '0;
               i_in         = '0;
               nout_in      = '0;
               k_in         = 3'd0;
               have_prev_in = 1'b0;
               have_best_in = 1'b0;
               case (req_tuser[1:0])
                  CMD_UPDATE: state_in = S_UPD_RD;
                  CMD_QUERY: begin
                     state_in = (req_tdata[47:16] >= 32'(in_use_ff)) ? S_ONE : S_QRY_RD;
                  end
                  CMD_STATS: state_in = S_STAT;
                  default: begin
                     fnv_ctrl.init = 1'b1;
                     state_in      = S_CK_EX;
                  end
               endcase
            end
         end
         S_UPD_RD: begin
            state_in = S_UPD_CHK;
         end
         S_UPD_CHK: begin
            if (out_free) begin
               emit                = 1'b1;
               em_last             = 1'b1;
               state_in            = S_IDLE;
               cnt_in[CNT_RECV]    = cnt_ff[CNT_RECV] + 64'd1;
               if (bad_ex || bad_in || bad_pr || bad_sq) begin
                  cnt_in[CNT_INVAL] = cnt_ff[CNT_INVAL] + 64'd1;
                  if (bad_ex)      em_status = ST_BAD_EXCHANGE;
                  else if (bad_in) em_status = ST_BAD_INSTR;
                  else if (bad_pr) em_status = ST_BAD_PRICE;
                  else             em_status = ST_BAD_SEQ;
               end else if (dup) begin
                  cnt_in[CNT_DUP] = cnt_ff[CNT_DUP] + 64'd1;
                  em_status       = ST_DUPLICATE;
               end else if (stale) begin
                  cnt_in[CNT_STALE] = cnt_ff[CNT_STALE] + 64'd1;
                  em_status         = ST_STALE;
               end else begin
                  seq_we           = 1'b1;
                  tbl_we           = 1'b1;
                  tbl_addr         = upd_addr;
                  tbl_wd.vld       = 1'b1;
                  tbl_wd.price     = price_ff[62:0];
                  tbl_wd.seq       = seq_ff;
                  tbl_wd.ts        = ts_ff;
                  cnt_in[CNT_ACC]  = cnt_ff[CNT_ACC] + 64'd1;
                  if (miss != 64'd0) begin
                     cnt_in[CNT_GAPS] = cnt_ff[CNT_GAPS] + 64'd1;
                     cnt_in[CNT_MISS] = cnt_ff[CNT_MISS] + miss;
                     em_status        = ST_GAP;
                     em_gap           = miss;
                  end
               end
            end
         end
         S_QRY_RD: begin
            state_in = S_QRY_CMP;
         end
         S_QRY_CMP: begin
            // keep the lowest entry above the last one sent
            if (cand && better) begin
               have_best_in = 1'b1;
               best_in      = tbl_rd_ff;
               best_exch_in = e_ff[XW-1:0];
            end
            e_in     = e_nxt;
            state_in = e_last ? S_QRY_OUT : S_QRY_RD;
         end
         S_QRY_OUT: begin
            if (!have_best_ff) begin
               e_in     = '0;
               state_in = S_MIS_RD;
            end else if (out_free) begin
               emit          = 1'b1;
               em_status     = ST_PRICE;
               em_exch       = 3'(best_exch_ff);
               em_price      = best_ff.price;
               em_seq        = best_ff.seq;
               em_ts         = best_ff.ts;
               em_last       = out_last;
               nout_in       = nout_nxt;
               have_prev_in  = 1'b1;
               prev_price_in = best_ff.price;
               prev_exch_in  = best_exch_ff;
               have_best_in  = 1'b0;
               e_in          = '0;
               state_in      = S_QRY_RD;
            end
         end
         S_MIS_RD: begin
            state_in = S_MIS_CHK;
         end
         S_MIS_CHK: begin
            if (tbl_rd_ff.vld || out_free) begin
               if (!tbl_rd_ff.vld) begin
                  emit      = 1'b1;
                  em_status = ST_MISSING;
                  em_exch   = 3'(e_ff[XW-1:0]);
                  em_last   = out_last;
                  nout_in   = nout_nxt;
               end
               e_in     = e_nxt;
               state_in = e_last ? S_IDLE : S_MIS_RD;
            end
         end
         S_STAT: begin
            if (out_free) begin
               emit      = 1'b1;
               em_status = ST_COUNTER;
               em_value  = cnt_ff[k_ff];
               em_last   = (k_ff == CNT_INVAL);
               k_in      = k_ff + 3'd1;
               if (k_ff == CNT_INVAL) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ONE: begin
            if (out_free) begin
               emit      = 1'b1;
               em_status = ST_NOT_FOUND;
               em_last   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CK_EX: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = {60'd0, ex_use_ff};
               state_in       = S_CK_IN;
            end
         end
         S_CK_IN: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = {53'd0, in_use_ff};
               state_in       = S_CK_SRD;
            end
         end
         S_CK_SRD: begin
            state_in = S_CK_SMIX;
         end
         S_CK_SMIX: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = last_seq;
               if (e_last) begin
                  e_in     = '0;
                  state_in = S_CK_RRD;
               end else begin
                  e_in     = e_nxt;
                  state_in = S_CK_SRD;
               end
            end
         end
         S_CK_RRD: begin
            state_in = S_CK_RV;
         end
         S_CK_RV, S_CK_RT: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = (state_ff == S_CK_RV) ? {63'd0, tbl_rd_ff.vld} : tbl_rd_ff.ts;
               if ((state_ff == S_CK_RV) && tbl_rd_ff.vld) begin
                  state_in = S_CK_RP;
               end else if (!e_last) begin
                  e_in     = e_nxt;
                  state_in = S_CK_RRD;
               end else begin
                  e_in     = '0;
                  i_in     = i_nxt;
                  state_in = i_last ? S_CK_OUT : S_CK_RRD;
               end
            end
         end
         S_CK_RP: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = {1'b0, tbl_rd_ff.price};
               state_in       = S_CK_RS;
            end
         end
         S_CK_RS: begin
            if (!fnv_busy) begin
               fnv_ctrl.start = 1'b1;
               fnv_ctrl.data  = tbl_rd_ff.seq;
               state_in       = S_CK_RT;
            end
         end
         S_CK_OUT: begin
            if (!fnv_busy && out_free) begin
               emit      = 1'b1;
               em_status = ST_CHECKSUM;
               em_value  = fnv_hash;
               em_last   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, em_value, em_ts, em_seq, em_price, em_exch, em_gap};
         rsp_user_in  = em_status;
         rsp_last_in  = em_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ex_use_ff    <= EX_RST;
         in_use_ff    <= IN_RST;
         rsp_valid_ff <= 1'b0;
         seq_vld_ff   <= '0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         e_ff         <= '0;
         i_ff         <= '0;
         nout_ff      <= '0;
         k_ff         <= 3'd0;
         for (int n = 0; n < NUM_CNT; n++) begin
            cnt_ff[n] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ex_use_ff    <= ex_use_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
         have_best_ff <= have_best_in;
         e_ff         <= e_in;
         i_ff         <= i_in;
         nout_ff      <= nout_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         if (seq_we) begin
            seq_vld_ff[seq_addr] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      exch_ff       <= exch_in;
      instr_ff      <= instr_in;
      price_ff      <= price_in;
      seq_ff        <= seq_in;
      ts_ff         <= ts_in;
      prev_price_ff <= prev_price_in;
      prev_exch_ff  <= prev_exch_in;
      best_ff       <= best_in;
      best_exch_ff  <= best_exch_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // sequence memory
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_addr] <= seq_ff;
      end
      seq_rd_ff     <= seq_mem[seq_addr];
      seq_rd_vld_ff <= seq_vld_ff[seq_addr];
   end

   // table memory
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_addr] <= tbl_wd;
      end
      tbl_rd_ff <= tbl_mem[tbl_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/spt_checker.sv
`include "sequenced_price_table_unit_macros.svh"

// port-level checks on the result stream
module spt_checker import spt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled item holds
   `SPT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")

   // update, checksum and not-found answers are single items
   `SPT_ASSERT(a_single_last, rsp_tvalid && (rsp_tuser <= ST_BAD_SEQ || rsp_tuser == ST_CHECKSUM || rsp_tuser == ST_NOT_FOUND) |-> rsp_tlast, "single result without last")

   // gap size only on a gap
   `SPT_ASSERT(a_gap_zero, rsp_tvalid && rsp_tuser != ST_GAP |-> rsp_tdata[63:0] == 64'd0, "gap size outside gap result")

   // clearing pass after reset blocks items and results
   `SPT_ASSERT_RST(a_rst_quiet, reset |=> !req_tready && !rsp_tvalid, "activity right after reset")

endmodule

bind sequenced_price_table_unit spt_checker u_spt_checker (.*);
